@@ src/psd_pkg.sv @@
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants for the population standard deviation block.
// ----------------------------------------------------------------------------
package psd_pkg;

  // Sample format and set length.
  localparam int SAMPLE_BITS  = 16;
  localparam int MAX_ELEMENTS = 4096;

  // Accumulator widths.
  localparam int CNT_W = 13;               // holds MAX_ELEMENTS itself
  localparam int SUM_W = 28;               // signed running sum
  localparam int SQR_W = 2 * SAMPLE_BITS - 1; // one square, at most 2^30
  localparam int SQ_W  = 43;               // running sum of squares

  // Back end arithmetic widths.
  localparam int MUL_SPLIT = 22;                   // low slice of the square sum
  localparam int VAR_W     = 56;                   // n*S2 - S1^2
  localparam int FRAC_BITS = 16;                   // radicand scaled by 2^16
  localparam int RAD_W     = VAR_W + FRAC_BITS;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int STEP_W    = $clog2(ROOT_W);
  localparam int DEV_W     = 24;

  // Summary queue depth.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One finished set handed from the front end to the back end.
  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sq_sum;
    logic                    too_many;
  } set_sum_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

endpackage

@@ src/psd_front.sv @@
// ----------------------------------------------------------------------------
// psd_front
// Accepts samples, squares them, and keeps the running count, sum and sum of
// squares. On the last sample of a set it pushes a summary into the queue.
// ----------------------------------------------------------------------------
module psd_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [psd_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                in_last_sample,
  output logic                                push,
  output psd_pkg::set_sum_t                   push_data,
  input  psd_pkg::q_status_t                  q_stat
);
  import psd_pkg::*;

  logic signed [2*SAMPLE_BITS-1:0] square;
  logic                            s1_valid_r;
  logic                            s1_last_r;
  logic signed [SUM_W-1:0]         s1_ext_r;
  logic [SQR_W-1:0]                s1_sq_r;
  logic                            s1_advance;

  logic [CNT_W-1:0]        cnt_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]         sq_r;
  logic                    ovf_r;
  logic                    set_full;
  logic [CNT_W-1:0]        cnt_nxt;
  logic signed [SUM_W-1:0] sum_nxt;
  logic [SQ_W-1:0]         sq_nxt;
  logic                    ovf_nxt;

  // The first stage squares the sample; it stalls only when a finished set
  // cannot enter a full queue.
  assign square     = in_sample * in_sample;
  assign s1_advance = s1_valid_r && !(s1_last_r && q_stat.full);
  assign in_ready   = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_last_r <= in_last_sample;
      s1_ext_r  <= {{(SUM_W - SAMPLE_BITS){in_sample[SAMPLE_BITS-1]}}, in_sample};
      s1_sq_r   <= square[SQR_W-1:0];
    end
  end

  // Samples past the set limit are dropped and only mark the set.
  assign set_full = (cnt_r == CNT_W'(MAX_ELEMENTS));
  assign cnt_nxt  = set_full ? cnt_r : cnt_r + 1'b1;
  assign sum_nxt  = set_full ? sum_r : sum_r + s1_ext_r;
  assign sq_nxt   = set_full ? sq_r : sq_r + SQ_W'(s1_sq_r);
  assign ovf_nxt  = ovf_r | set_full;

  // Accumulators clear once the summary of a set has been pushed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      sq_r  <= '0;
      ovf_r <= 1'b0;
    end else if (s1_advance) begin
      if (s1_last_r) begin
        cnt_r <= '0;
        sum_r <= '0;
        sq_r  <= '0;
        ovf_r <= 1'b0;
      end else begin
        cnt_r <= cnt_nxt;
        sum_r <= sum_nxt;
        sq_r  <= sq_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

  // Summary of the set, including its final sample.
  assign push               = s1_advance && s1_last_r;
  assign push_data.count    = cnt_nxt;
  assign push_data.sum      = sum_nxt;
  assign push_data.sq_sum   = sq_nxt;
  assign push_data.too_many = ovf_nxt;

endmodule

@@ src/psd_queue.sv @@
// ----------------------------------------------------------------------------
// psd_queue
// Small FIFO of set summaries between the front end and the back end.
// ----------------------------------------------------------------------------
module psd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  psd_pkg::set_sum_t   push_data,
  input  logic                pop,
  output psd_pkg::set_sum_t   pop_data,
  output psd_pkg::q_status_t  q_stat
);
  import psd_pkg::*;

  set_sum_t            entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r;
  logic [Q_PTR_W-1:0]  rd_ptr_r;
  logic [Q_CNT_W-1:0]  cnt_r;

  assign q_stat.full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_stat.not_empty = (cnt_r != '0);
  assign pop_data         = entry_r[rd_ptr_r];

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ src/psd_back.sv @@
// ----------------------------------------------------------------------------
// psd_back
// Turns one set summary into the deviation: n*S2 in two partial products,
// the variance, a bit-serial square root and a bit-serial divide by n.
// ----------------------------------------------------------------------------
module psd_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  psd_pkg::q_status_t              q_stat,
  output logic                            pop,
  input  psd_pkg::set_sum_t               pop_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [psd_pkg::DEV_W-1:0]       out_std_dev_q16_8,
  output logic [psd_pkg::CNT_W-1:0]       out_element_total,
  output logic                            out_too_many
);
  import psd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUB,
    ST_SQRT,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                          state_r;
  logic [CNT_W-1:0]                n_r;
  logic [SUM_W-1:0]                abs_r;
  logic [SQ_W-1:0]                 s2_r;
  logic                            ovf_r;
  logic [CNT_W+MUL_SPLIT-1:0]      prod_r;
  logic [VAR_W-1:0]                sq_r;
  logic [VAR_W-1:0]                a_r;
  logic [RAD_W-1:0]                rad_r;
  logic [REM_W-1:0]                rem_r;
  logic [ROOT_W-1:0]               root_r;
  logic [CNT_W-1:0]                drem_r;
  logic [STEP_W-1:0]               step_r;
  logic                            out_valid_r;
  logic [DEV_W-1:0]                dev_r;
  logic [CNT_W-1:0]                tot_r;
  logic                            tm_r;

  logic [SUM_W-1:0]                abs_nxt;
  logic [CNT_W+MUL_SPLIT-1:0]      p_lo;
  logic [CNT_W+SQ_W-MUL_SPLIT-1:0] p_hi;
  logic [VAR_W-1:0]                sq_full;
  logic [VAR_W-1:0]                a_nxt;
  logic [VAR_W-1:0]                var_nxt;
  logic [REM_W+1:0]                rem_t;
  logic [REM_W+1:0]                rem_sub;
  logic [REM_W-1:0]                test;
  logic                            sq_ge;
  logic [CNT_W:0]                  d_t;
  logic [CNT_W:0]                  d_sub;
  logic                            d_ge;
  logic                            last_step;

  // Magnitude of the sum; only its square is needed.
  assign abs_nxt = pop_data.sum[SUM_W-1] ? (~pop_data.sum + 1'b1) : pop_data.sum;

  // Partial products of n*S2 and the square of the sum.
  assign p_lo    = (CNT_W+MUL_SPLIT)'(n_r) * (CNT_W+MUL_SPLIT)'(s2_r[MUL_SPLIT-1:0]);
  assign p_hi    = (CNT_W+SQ_W-MUL_SPLIT)'(n_r)
                 * (CNT_W+SQ_W-MUL_SPLIT)'(s2_r[SQ_W-1:MUL_SPLIT]);
  assign sq_full = VAR_W'(abs_r) * VAR_W'(abs_r);
  assign a_nxt   = VAR_W'(prod_r) + (VAR_W'(p_hi) << MUL_SPLIT);

  // Variance numerator, clamped at zero; a too-long set gives zero.
  assign var_nxt = (ovf_r || (a_r < sq_r)) ? '0 : a_r - sq_r;

  // One square root digit per cycle.
  assign rem_t   = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign test    = {root_r, 2'b01};
  assign sq_ge   = (rem_t >= (REM_W+2)'(test));
  assign rem_sub = rem_t - (REM_W+2)'(test);

  // One quotient bit per cycle.
  assign d_t   = {drem_r, root_r[ROOT_W-1]};
  assign d_ge  = (d_t >= {1'b0, n_r});
  assign d_sub = d_t - {1'b0, n_r};

  assign last_step = (step_r == STEP_W'(ROOT_W - 1));
  assign pop       = (state_r == ST_IDLE) && q_stat.not_empty;

  // Sequencer with the arithmetic registers and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      // A taken result clears unless a new one replaces it in the same cycle.
      if (out_valid_r && out_ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_stat.not_empty) begin
            n_r     <= pop_data.count;
            abs_r   <= abs_nxt;
            s2_r    <= pop_data.sq_sum;
            ovf_r   <= pop_data.too_many;
            state_r <= ST_MUL_LO;
          end
        end
        ST_MUL_LO: begin
          prod_r  <= p_lo;
          sq_r    <= sq_full;
          state_r <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          a_r     <= a_nxt;
          state_r <= ST_SUB;
        end
        ST_SUB: begin
          rad_r   <= {var_nxt, {FRAC_BITS{1'b0}}};
          rem_r   <= '0;
          root_r  <= '0;
          step_r  <= '0;
          state_r <= ST_SQRT;
        end
        ST_SQRT: begin
          rem_r  <= sq_ge ? rem_sub[REM_W-1:0] : rem_t[REM_W-1:0];
          root_r <= {root_r[ROOT_W-2:0], sq_ge};
          rad_r  <= rad_r << 2;
          if (last_step) begin
            step_r  <= '0;
            drem_r  <= '0;
            state_r <= ST_DIV;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_DIV: begin
          drem_r <= d_ge ? d_sub[CNT_W-1:0] : d_t[CNT_W-1:0];
          root_r <= {root_r[ROOT_W-2:0], d_ge};
          if (last_step) begin
            step_r  <= '0;
            state_r <= ST_DONE;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            dev_r       <= root_r[DEV_W-1:0];
            tot_r       <= n_r;
            tm_r        <= ovf_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_std_dev_q16_8 = dev_r;
  assign out_element_total = tot_r;
  assign out_too_many      = tm_r;

endmodule

@@ src/population_std_deviation.sv @@
// ----------------------------------------------------------------------------
// population_std_deviation
// Streaming population standard deviation of signed samples, Q16.8 result.
// ----------------------------------------------------------------------------
// Samples are taken at one per cycle while in_ready is high; a set ends with
// the sample that carries in_last_sample. For each set one transaction leaves
// on the out_ channel with floor(isqrt(65536*(n*S2 - S1^2)) / n), the sample
// count and a flag for sets longer than 4096 samples (the extra samples are
// dropped and the deviation reads zero). The front end accumulates, and a
// queue holds up to two finished set summaries; the back end takes one set
// at a time (a pop, two multiply steps, a subtract, a bit-serial square root,
// a bit-serial divide and a result). When sets arrive faster than the back
// end drains them, the queue fills and in_ready drops on a last sample until
// a summary slot frees up.
module population_std_deviation (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [psd_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                   in_last_sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [psd_pkg::DEV_W-1:0]              out_std_dev_q16_8,
  output logic [psd_pkg::CNT_W-1:0]              out_element_total,
  output logic                                   out_too_many
);
  import psd_pkg::*;

  logic      push;
  logic      pop;
  set_sum_t  push_data;
  set_sum_t  pop_data;
  q_status_t q_stat;

  // Sample intake and accumulation.
  psd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_last_sample (in_last_sample),
    .push           (push),
    .push_data      (push_data),
    .q_stat         (q_stat)
  );

  // Finished set summaries waiting for the back end.
  psd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // Variance, square root and division.
  psd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .pop               (pop),
    .pop_data          (pop_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_std_dev_q16_8 (out_std_dev_q16_8),
    .out_element_total (out_element_total),
    .out_too_many      (out_too_many)
  );

  // A flagged set always reports zero deviation.
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_too_many) |-> (out_std_dev_q16_8 == '0))
    else $error("too_many result with nonzero deviation");

  // Every result covers between one and MAX_ELEMENTS samples.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_element_total != '0) &&
                   (out_element_total <= CNT_W'(MAX_ELEMENTS))))
    else $error("element_total out of range");

  // The intake only stalls because the summary queue is full.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_stat.full)
    else $error("intake stalled with room in the queue");

  // A summary never enters a full queue unless one leaves at the same time.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!q_stat.full || pop))
    else $error("push into a full summary queue");

endmodule

@@ test/std_dev_checker.sv @@
// ----------------------------------------------------------------------------
// std_dev_checker
// Watches both channels of the standard deviation block, predicts each set
// result from the accepted samples and compares it with what comes out.
// ----------------------------------------------------------------------------
module std_dev_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic signed [psd_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                   in_last_sample,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic [psd_pkg::DEV_W-1:0]              out_std_dev_q16_8,
  input  logic [psd_pkg::CNT_W-1:0]              out_element_total,
  input  logic                                   out_too_many,
  output int                                     mismatch_count,
  output int                                     results_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import psd_pkg::*;

  typedef struct {
    logic [DEV_W-1:0] dev;
    logic [CNT_W-1:0] total;
    logic             too_many;
  } set_result_t;

  // Running state of the set being accumulated.
  longint          set_sum;
  longint unsigned set_sq_sum;
  int unsigned     set_count;
  bit              set_overflow;

  // Results predicted for finished sets, oldest first.
  set_result_t set_results_due[$];

  // Digit-by-digit square root of v extended by 16 zero bits.
  function automatic logic [39:0] root_scaled(input logic [63:0] v);
    logic [79:0] radicand;
    logic [41:0] remainder;
    logic [41:0] trial;
    logic [39:0] root;
    radicand  = {v, 16'b0};
    remainder = '0;
    root      = '0;
    for (int i = 0; i < 40; i++) begin
      remainder = {remainder[39:0], radicand[79-2*i -: 2]};
      trial     = {root, 2'b01};
      if (remainder >= trial) begin
        remainder = remainder - trial;
        root      = {root[38:0], 1'b1};
      end else begin
        root = {root[38:0], 1'b0};
      end
    end
    return root;
  endfunction

  // Folds one sample into the set and predicts the result on the last one.
  task automatic accumulate_sample(input logic signed [SAMPLE_BITS-1:0] s,
                                   input logic last);
    longint unsigned mag;
    longint unsigned abs_sum;
    longint unsigned scaled;
    longint unsigned spread;
    longint unsigned root;
    set_result_t     res;
    mag = (s < 0) ? -longint'(s) : longint'(s);

    // Samples beyond the set limit are dropped and only flag the set.
    if (set_count >= MAX_ELEMENTS) begin
      set_overflow = 1'b1;
    end else begin
      set_sum    += longint'(s);
      set_sq_sum += mag * mag;
      set_count++;
    end

    if (last) begin
      res.dev = '0;
      if (!set_overflow && set_count != 0) begin
        abs_sum = (set_sum < 0) ? -set_sum : set_sum;
        scaled  = set_count * set_sq_sum;
        spread  = (scaled >= abs_sum * abs_sum) ? scaled - abs_sum * abs_sum : 0;
        root    = root_scaled(spread);
        res.dev = DEV_W'(root / set_count);
      end
      res.total    = CNT_W'(set_count);
      res.too_many = set_overflow;
      set_results_due.push_back(res);
      set_sum      = 0;
      set_sq_sum   = 0;
      set_count    = 0;
      set_overflow = 1'b0;
    end
  endtask

  // Sample both channels at the rising edge; samples go in before results
  // come out so that the queue order matches the block's.
  always @(posedge clk) begin
    set_result_t want;
    if (!rst_n) begin
      set_sum      = 0;
      set_sq_sum   = 0;
      set_count    = 0;
      set_overflow = 1'b0;
      set_results_due.delete();
      mismatch_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        accumulate_sample(in_sample, in_last_sample);
      end
      if (out_valid && out_ready) begin
        if (set_results_due.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: unexpected result transaction dev=%0d total=%0d too_many=%0d",
                     $realtime, out_std_dev_q16_8, out_element_total, out_too_many);
          end
          mismatch_count++;
        end else begin
          want = set_results_due.pop_front();
          if (out_std_dev_q16_8 !== want.dev || out_element_total !== want.total ||
              out_too_many !== want.too_many) begin
            if (mismatch_count < 10) begin
              $display("%0t: result mismatch: expected dev=%0d total=%0d too_many=%0d",
                       $realtime, want.dev, want.total, want.too_many);
              $display("%0t:                  actual   dev=%0d total=%0d too_many=%0d",
                       $realtime, out_std_dev_q16_8, out_element_total, out_too_many);
            end
            mismatch_count++;
          end
        end
      end
    end
    results_outstanding = set_results_due.size();
  end

endmodule

@@ test/population_std_deviation_test.sv @@
// ----------------------------------------------------------------------------
// population_std_deviation_test
// Drives sample sets into the standard deviation block: directed extremes,
// maximum-length and overlong sets, then random sets with random idling on
// both channels. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module population_std_deviation_test;
  timeunit 1ns;
  timeprecision 1ps;
  import psd_pkg::*;

  // Cycles without any transaction before the run is declared hung. A correct
  // block stalls at most a few back end passes.
  localparam int HANG_LIMIT    = 3000;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int DRAIN_CYCLES  = 200;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                    in_last_sample;
  logic                    out_valid;
  logic                    out_ready;
  logic [DEV_W-1:0]        out_std_dev_q16_8;
  logic [CNT_W-1:0]        out_element_total;
  logic                    out_too_many;

  int mismatch_count;
  int results_outstanding;
  int samples_sent;
  int quiet_cycles;
  bit sender_idles;
  bit receiver_idles;

  population_std_deviation uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .in_last_sample    (in_last_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_std_dev_q16_8 (out_std_dev_q16_8),
    .out_element_total (out_element_total),
    .out_too_many      (out_too_many)
  );

  std_dev_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_sample           (in_sample),
    .in_last_sample      (in_last_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_std_dev_q16_8   (out_std_dev_q16_8),
    .out_element_total   (out_element_total),
    .out_too_many        (out_too_many),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding)
  );

  // Clock with a 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sends one sample transaction after an optional gap; returns at the edge
  // that accepted it.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic last);
    int gap;
    gap = sender_idles ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_sample      <= s;
    in_last_sample <= last;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  // Random sample weighted toward the extremes and small values.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'($urandom_range(0, 8) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // Sends a whole set of random samples.
  task automatic send_random_set(input int len);
    for (int k = 1; k <= len; k++) begin
      send_sample(pick_sample(), k == len);
    end
  endtask

  // Holds the sender idle until every predicted result has come out.
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (results_outstanding == 0);
  endtask

  // Result side: random stalls per transaction, with stretches of none.
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      stall = receiver_idles ? $urandom_range(0, 9) : 0;
      repeat (stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int len;
    int random_start;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_sample      = '0;
    in_last_sample = 1'b0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    samples_sent   = 0;
    quiet_cycles   = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Single-sample sets at the extremes and zero.
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b1);
    // Largest spread, in both orders.
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b1);
    // Equal samples give zero deviation.
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b1);
    // Small mixed set.
    send_sample(16'sh0001, 1'b0);
    send_sample(16'shFFFF, 1'b0);
    send_sample(16'sh0002, 1'b0);
    send_sample(16'shFFFE, 1'b0);
    send_sample(16'sh3039, 1'b1);
    wait_for_drain();

    // A set of exactly the maximum length, then one two samples too long,
    // whose last sample is itself dropped.
    sender_idles = 1'b0;
    send_random_set(MAX_ELEMENTS);
    send_random_set(MAX_ELEMENTS + 2);
    wait_for_drain();

    // Random sets, mostly short, with changing idle patterns and an
    // occasional full drain.
    random_start = samples_sent;
    while (samples_sent - random_start < RANDOM_ITEMS) begin
      sender_idles   = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 150) : $urandom_range(1, 16);
      send_random_set(len);
      if ($urandom_range(0, 24) == 0) begin
        wait_for_drain();
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Let the last results out, then watch for strays.
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
